>>> design/earth_rotation_table_interpolator_core_macros.svh
// Assertion helpers for the earth rotation table interpolator.
// All assertions sample on clk and are disabled while arst_n is low.
`ifndef EARTH_ROTATION_TABLE_INTERPOLATOR_CORE_MACROS_SVH
`define EARTH_ROTATION_TABLE_INTERPOLATOR_CORE_MACROS_SVH

// Same-cycle implication.
`define ERTIC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ERTIC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/ertic_pkg.sv
// ----------------------------------------------------------------------------
// ertic_pkg
// Shared constants for the earth rotation table interpolator: table depth,
// field widths, transaction kinds, status codes and the scale unit request.
// ----------------------------------------------------------------------------
package ertic_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	localparam int TW = 41;   // time stamp width
	localparam int VW = 48;   // value width
	localparam int DW = 6 * VW; // packed entry values

	// transaction kinds
	localparam logic [1:0] KIND_QUERY  = 2'd0;
	localparam logic [1:0] KIND_APPEND = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// scale unit request
	typedef struct packed {
		logic          start;
		logic [VW:0]   a_mag;  // value magnitude, below 2^48
		logic [VW-1:0] b_mag;  // weight or day magnitude
		logic          sh32;   // shift by 32 when set, else by 24
		logic          neg;    // negate the result
	} scale_req_t;

endpackage

>>> design/ertic_ram.sv
// ----------------------------------------------------------------------------
// ertic_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ertic_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> design/ertic_scale.sv
// ----------------------------------------------------------------------------
// ertic_scale
// Iterative scaled product: round(a*b / 2^sh) with ties away from zero,
// clamped to 2^62 and signed. Three 49x16 partial products, then rounding.
// ----------------------------------------------------------------------------
module ertic_scale (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ertic_pkg::scale_req_t    req,
	output logic                     done,
	output logic signed [63:0]       result
);
	import ertic_pkg::*;

	localparam int PW = 2 * VW + 1;

	logic [VW:0]       a_q;
	logic [VW-1:0]     b_q;
	logic [PW-1:0]     acc_q;
	logic [1:0]        cnt_q;
	logic              busy_q;
	logic              sh32_q;
	logic              neg_q;
	logic              done_q;
	logic signed [63:0] result_q;

	logic [VW+16:0]    pp;
	logic [PW-1:0]     rnd_sum;
	logic [PW-1:0]     shifted;
	logic [62:0]       mag_clamped;

	// partial product of a and the current high chunk of b
	assign pp = {16'd0, a_q} * {{(VW+1){1'b0}}, b_q[VW-1:VW-16]};

	// round, shift and clamp the finished product
	always_comb begin
		rnd_sum = acc_q + (sh32_q ? (PW'(1) << 31) : (PW'(1) << 23));
		shifted = sh32_q ? (rnd_sum >> 32) : (rnd_sum >> 24);
		if (shifted > (PW'(1) << 62)) begin
			mag_clamped = 63'(64'd1 << 62);
		end else begin
			mag_clamped = shifted[62:0];
		end
	end

	// control of the partial product sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 2'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == 2'd0);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd3;
			end else if (busy_q) begin
				if (cnt_q != 2'd0) begin
					cnt_q <= cnt_q - 2'd1;
				end else begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// accumulate one 16-bit chunk of b per cycle, high chunk first
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q    <= req.a_mag;
			b_q    <= req.b_mag;
			acc_q  <= '0;
			sh32_q <= req.sh32;
			neg_q  <= req.neg;
		end else if (busy_q) begin
			if (cnt_q != 2'd0) begin
				acc_q <= (acc_q << 16) + PW'(pp);
				b_q   <= b_q << 16;
			end else begin
				result_q <= neg_q ? -$signed({1'b0, mag_clamped}) : $signed({1'b0, mag_clamped});
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

>>> design/earth_rotation_table_interpolator_core.sv
// Append, clear and empty-table query: straight to the done state; the result loads
// once the output register is free. Query: binary search steps (one time RAM read
// each), bit-serial division for the 32-bit weight, then four products on the shared
// scaled-product unit before the result loads.
// One transaction at a time; input is ready again the cycle after the result
// loads. Reset clears entry count and control; table RAM keeps data.
// ----------------------------------------------------------------------------
// earth_rotation_table_interpolator_core
// Earth rotation table with binary search and linear interpolation or
// end-point extrapolation, sequenced over one shared multiply unit.
// ----------------------------------------------------------------------------
`include "earth_rotation_table_interpolator_core_macros.svh"

module earth_rotation_table_interpolator_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    kind,
	input  logic [ertic_pkg::TW-1:0]      time_days,
	input  logic signed [ertic_pkg::VW-1:0] pole_x,
	input  logic signed [ertic_pkg::VW-1:0] pole_y,
	input  logic signed [ertic_pkg::VW-1:0] ut1_minus_utc,
	input  logic signed [ertic_pkg::VW-1:0] day_length_excess,
	input  logic signed [ertic_pkg::VW-1:0] pole_x_rate,
	input  logic signed [ertic_pkg::VW-1:0] pole_y_rate,
	input  logic [7:0]                    leap_seconds_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic signed [ertic_pkg::VW-1:0] pole_x_out,
	output logic signed [ertic_pkg::VW-1:0] pole_y_out,
	output logic signed [ertic_pkg::VW-1:0] ut1_minus_utc_out,
	output logic signed [ertic_pkg::VW-1:0] day_length_out,
	output logic [7:0]                    leap_seconds_out
);
	import ertic_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_T0   = 4'd1;
	localparam logic [3:0] S_C0   = 4'd2;
	localparam logic [3:0] S_C1   = 4'd3;
	localparam logic [3:0] S_SRCH = 4'd4;
	localparam logic [3:0] S_SCMP = 4'd5;
	localparam logic [3:0] S_TJ   = 4'd6;
	localparam logic [3:0] S_TJ1  = 4'd7;
	localparam logic [3:0] S_DIV  = 4'd8;
	localparam logic [3:0] S_LO   = 4'd9;
	localparam logic [3:0] S_HI   = 4'd10;
	localparam logic [3:0] S_HIW  = 4'd11;
	localparam logic [3:0] S_EXTD = 4'd12;
	localparam logic [3:0] S_MUL  = 4'd13;
	localparam logic [3:0] S_MULW = 4'd14;
	localparam logic [3:0] S_DONE = 4'd15;

	logic [3:0]  state_q;
	logic [CW-1:0] count_q;
	logic [1:0]  kind_q;
	logic [TW-1:0] t_q;
	logic [7:0]  leap_q;
	logic [1:0]  stat_q;
	logic        vals_q;
	logic [AW-1:0] j_q, k_q, mid_q;
	logic [TW-1:0] tj_q;
	logic [TW-1:0] d_q, r_q;
	logic [31:0] a_q;
	logic [5:0]  cnt_q;
	logic [1:0]  op_q;
	logic        ext_q;
	logic signed [TW:0] day_q;
	logic signed [VW-1:0] base_q [4];
	logic signed [VW-1:0] oth_q [4];
	logic signed [VW-1:0] res_q [4];

	logic        out_valid_q;
	logic [1:0]  status_q;
	logic signed [VW-1:0] px_q, py_q, ut1_q, lod_q;
	logic [7:0]  leap_out_q;

	// RAM ports
	logic          accept;
	logic          wr_en;
	logic [AW-1:0] last_idx;
	logic [AW-1:0] t_raddr;
	logic [AW-1:0] d_raddr;
	logic [TW-1:0] t_rdata;
	logic [DW-1:0] d_rdata;
	logic [AW:0]   mid_sum;
	logic          search_more;

	// scale unit
	scale_req_t            sreq;
	logic                  sdone;
	logic signed [63:0]    sres;
	logic signed [VW:0]    op_v;
	logic signed [VW-1:0]  op_w;
	logic                  op_sub;
	logic signed [64:0]    sum;
	logic signed [VW-1:0]  sum_sat;

	// divider step
	logic [TW:0]   r2;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign wr_en    = accept && (kind == KIND_APPEND) && (count_q < CW'(TABLE_DEPTH));
	assign last_idx = AW'(count_q - CW'(1));
	assign mid_sum  = {1'b0, j_q} + {1'b0, k_q};
	assign search_more = ({1'b0, j_q} + (AW+1)'(1)) < {1'b0, k_q};

	// time RAM read address by state
	always_comb begin
		case (state_q)
			S_C0:    t_raddr = last_idx;
			S_SRCH:  t_raddr = search_more ? mid_sum[AW:1] : j_q;
			S_TJ:    t_raddr = j_q + AW'(1);
			default: t_raddr = '0;
		endcase
	end

	assign d_raddr = (state_q == S_HI) ? (j_q + AW'(1)) : j_q;

	ertic_ram #(.WIDTH(TW), .DEPTH(TABLE_DEPTH)) u_time_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[AW-1:0]),
		.wdata (time_days),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	ertic_ram #(.WIDTH(DW), .DEPTH(TABLE_DEPTH)) u_data_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[AW-1:0]),
		.wdata ({pole_x, pole_y, ut1_minus_utc, day_length_excess, pole_x_rate,
			pole_y_rate}),
		.raddr (d_raddr),
		.rdata (d_rdata)
	);

	// operands of the current scale operation
	always_comb begin
		if (ext_q) begin
			op_v = {oth_q[0][VW-1], oth_q[0]};
			op_w = VW'(day_q);
		end else begin
			op_v = {oth_q[0][VW-1], oth_q[0]} - {base_q[0][VW-1], base_q[0]};
			op_w = {{(VW-32){1'b0}}, a_q};
		end
		op_sub     = ext_q && (op_q == 2'd2);
		sreq.start = (state_q == S_MUL);
		sreq.a_mag = op_v[VW] ? (VW+1)'(-op_v) : (VW+1)'(op_v);
		sreq.b_mag = op_w[VW-1] ? VW'(-op_w) : VW'(op_w);
		sreq.sh32  = !ext_q;
		sreq.neg   = op_v[VW] ^ op_w[VW-1] ^ op_sub;
	end

	ertic_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sreq),
		.done   (sdone),
		.result (sres)
	);

	// add the scaled term and saturate to 48 bits
	always_comb begin
		sum = 65'(base_q[0]) + 65'(sres);
		if (sum > 65'sh7FFF_FFFF_FFFF) begin
			sum_sat = {1'b0, {(VW-1){1'b1}}};
		end else if (sum < -65'sh8000_0000_0000) begin
			sum_sat = {1'b1, {(VW-1){1'b0}}};
		end else begin
			sum_sat = sum[VW-1:0];
		end
	end

	assign r2 = {r_q, 1'b0};

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// raise valid on a loaded result, drop it once taken
			if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (kind == KIND_QUERY && count_q != '0) begin
							state_q <= S_T0;
						end else begin
							state_q <= S_DONE;
						end
						if (wr_en) begin
							count_q <= count_q + CW'(1);
						end
						if (kind == KIND_CLEAR) begin
							count_q <= '0;
						end
					end
				end
				S_T0:   state_q <= S_C0;
				S_C0:   state_q <= (t_q <= t_rdata) ? S_LO : S_C1;
				S_C1:   state_q <= (t_q >= t_rdata) ? S_LO : S_SRCH;
				S_SRCH: state_q <= search_more ? S_SCMP : S_TJ;
				S_SCMP: state_q <= S_SRCH;
				S_TJ:   state_q <= S_TJ1;
				S_TJ1: begin
					if (t_rdata <= tj_q || t_q < tj_q) begin
						state_q <= S_LO;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV:  state_q <= (cnt_q == 6'd1) ? S_LO : S_DIV;
				S_LO:   state_q <= ext_q ? S_EXTD : S_HI;
				S_HI:   state_q <= S_HIW;
				S_HIW:  state_q <= S_MUL;
				S_EXTD: state_q <= S_MUL;
				S_MUL:  state_q <= S_MULW;
				S_MULW: begin
					if (sdone) begin
						state_q <= (op_q == 2'd3) ? S_DONE : S_MUL;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				kind_q <= kind;
				t_q    <= time_days;
				leap_q <= leap_seconds_in;
				vals_q <= 1'b0;
				ext_q  <= 1'b0;
				op_q   <= 2'd0;
				if (kind == KIND_QUERY && count_q == '0) begin
					stat_q <= ST_EMPTY;
				end else if (kind == KIND_APPEND && !wr_en) begin
					stat_q <= ST_FULL;
				end else begin
					stat_q <= ST_OK;
				end
			end
			S_C0: begin
				tj_q  <= t_rdata;
				j_q   <= '0;
				ext_q <= (t_q <= t_rdata);
			end
			S_C1: begin
				tj_q  <= t_rdata;
				ext_q <= (t_q >= t_rdata);
				j_q   <= (t_q >= t_rdata) ? last_idx : '0;
				k_q   <= last_idx;
			end
			S_SRCH: mid_q <= mid_sum[AW:1];
			S_SCMP: begin
				if (t_q < t_rdata) begin
					k_q <= mid_q;
				end else begin
					j_q <= mid_q;
				end
			end
			S_TJ: tj_q <= t_rdata;
			S_TJ1: begin
				// weight one half when the division is skipped
				a_q   <= (t_rdata <= tj_q || t_q < tj_q) ? 32'h8000_0000 : 32'd0;
				cnt_q <= 6'd32;
				d_q   <= t_rdata - tj_q;
				if ((t_q - tj_q) >= (t_rdata - tj_q)) begin
					r_q <= t_rdata - tj_q - TW'(1);
				end else begin
					r_q <= t_q - tj_q;
				end
			end
			S_DIV: begin
				cnt_q <= cnt_q - 6'd1;
				if (r2 >= {1'b0, d_q}) begin
					r_q <= TW'(r2 - {1'b0, d_q});
					a_q <= {a_q[30:0], 1'b1};
				end else begin
					r_q <= r2[TW-1:0];
					a_q <= {a_q[30:0], 1'b0};
				end
			end
			S_HI: begin
				base_q[0] <= d_rdata[6*VW-1:5*VW];
				base_q[1] <= d_rdata[5*VW-1:4*VW];
				base_q[2] <= d_rdata[4*VW-1:3*VW];
				base_q[3] <= d_rdata[3*VW-1:2*VW];
			end
			S_HIW: begin
				oth_q[0] <= d_rdata[6*VW-1:5*VW];
				oth_q[1] <= d_rdata[5*VW-1:4*VW];
				oth_q[2] <= d_rdata[4*VW-1:3*VW];
				oth_q[3] <= d_rdata[3*VW-1:2*VW];
				vals_q   <= 1'b1;
			end
			S_EXTD: begin
				base_q[0] <= d_rdata[6*VW-1:5*VW];
				base_q[1] <= d_rdata[5*VW-1:4*VW];
				base_q[2] <= d_rdata[4*VW-1:3*VW];
				base_q[3] <= d_rdata[3*VW-1:2*VW];
				oth_q[0]  <= d_rdata[2*VW-1:VW];
				oth_q[1]  <= d_rdata[VW-1:0];
				oth_q[2]  <= d_rdata[3*VW-1:2*VW];
				oth_q[3]  <= '0;
				day_q     <= $signed({1'b0, t_q}) - $signed({1'b0, tj_q});
				vals_q    <= 1'b1;
			end
			S_MULW: begin
				// advance the lanes after each finished product
				if (sdone) begin
					op_q      <= op_q + 2'd1;
					base_q[0] <= base_q[1];
					base_q[1] <= base_q[2];
					base_q[2] <= base_q[3];
					oth_q[0]  <= oth_q[1];
					oth_q[1]  <= oth_q[2];
					oth_q[2]  <= oth_q[3];
					res_q[0]  <= res_q[1];
					res_q[1]  <= res_q[2];
					res_q[2]  <= res_q[3];
					res_q[3]  <= sum_sat;
				end
			end
			default: begin
			end
		endcase
	end

	// output register: load the finished transaction
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			status_q   <= stat_q;
			px_q       <= vals_q ? res_q[0] : '0;
			py_q       <= vals_q ? res_q[1] : '0;
			ut1_q      <= vals_q ? res_q[2] : '0;
			lod_q      <= vals_q ? res_q[3] : '0;
			leap_out_q <= (kind_q == KIND_QUERY && stat_q == ST_OK) ? leap_q : 8'd0;
		end
	end

	assign out_valid         = out_valid_q;
	assign status            = status_q;
	assign pole_x_out        = px_q;
	assign pole_y_out        = py_q;
	assign ut1_minus_utc_out = ut1_q;
	assign day_length_out    = lod_q;
	assign leap_seconds_out  = leap_out_q;

	`ERTIC_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready, "ready right after accept")
	`ERTIC_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(TABLE_DEPTH), "entry count over depth")
	`ERTIC_ASSERT_NOW(a_done_in_wait, sdone, state_q == S_MULW, "product done outside wait")
	`ERTIC_ASSERT_NOW(a_empty_no_leap, out_valid && status == ST_EMPTY, leap_seconds_out == 8'd0, "leap on empty")

endmodule

>>> tb/ertic_checker.sv
// ----------------------------------------------------------------------------
// ertic_checker
// Watches both channels of the earth rotation table interpolator, predicts
// each result from its own copy of the table and compares every field.
// ----------------------------------------------------------------------------
module ertic_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [1:0]        kind,
	input  logic [40:0]       time_days,
	input  logic signed [47:0] pole_x,
	input  logic signed [47:0] pole_y,
	input  logic signed [47:0] ut1_minus_utc,
	input  logic signed [47:0] day_length_excess,
	input  logic signed [47:0] pole_x_rate,
	input  logic signed [47:0] pole_y_rate,
	input  logic [7:0]        leap_seconds_in,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [1:0]        status,
	input  logic signed [47:0] pole_x_out,
	input  logic signed [47:0] pole_y_out,
	input  logic signed [47:0] ut1_minus_utc_out,
	input  logic signed [47:0] day_length_out,
	input  logic [7:0]        leap_seconds_out,
	output int                fail_count,
	output int                pending
);
	import ertic_pkg::*;

	typedef struct packed {
		logic [1:0]  st;
		logic [47:0] px;
		logic [47:0] py;
		logic [47:0] ut;
		logic [47:0] lod;
		logic [7:0]  leap;
	} eop_result_t;

	eop_result_t result_q[$];

	int          n_entries;
	logic [40:0] tab_time[TABLE_DEPTH];
	longint      tab_px[TABLE_DEPTH];
	longint      tab_py[TABLE_DEPTH];
	longint      tab_ut[TABLE_DEPTH];
	longint      tab_lod[TABLE_DEPTH];
	longint      tab_pxr[TABLE_DEPTH];
	longint      tab_pyr[TABLE_DEPTH];

	assign pending = result_q.size();

	function automatic logic [63:0] magnitude(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	// round(v*w/2^sh) ties away from zero, clamped to +-2^62
	function automatic longint scaled_product(longint v, longint w, int sh);
		logic [127:0] p;
		logic [63:0]  r;
		bit           neg;
		neg = (v < 0) != (w < 0);
		p = 128'(magnitude(v)) * 128'(magnitude(w));
		p = p + (128'(1) << (sh - 1));
		p = p >> sh;
		if (p > (128'(1) << 62))
			p = 128'(1) << 62;
		r = p[63:0];
		return neg ? -longint'(r) : longint'(r);
	endfunction

	function automatic logic [47:0] sat48(longint v);
		if (v > 64'sd140737488355327)
			return 48'h7FFF_FFFF_FFFF;
		if (v < -64'sd140737488355328)
			return 48'h8000_0000_0000;
		return v[47:0];
	endfunction

	function automatic logic [47:0] blend(longint lo, longint hi, longint a);
		return sat48(lo + scaled_product(hi - lo, a, 32));
	endfunction

	function automatic eop_result_t predict_result(logic [1:0] k, logic [40:0] t,
			logic [7:0] leap);
		eop_result_t res;
		int          e, j, hi, mid;
		longint      day, a;
		logic [63:0] d, r;
		logic [127:0] q;
		res = '0;
		if (k == KIND_QUERY) begin
			if (n_entries == 0) begin
				res.st = ST_EMPTY;
				return res;
			end
			res.leap = leap;
			if (t <= tab_time[0] || t >= tab_time[n_entries-1]) begin
				// extrapolate from the nearer end entry
				e = (t <= tab_time[0]) ? 0 : n_entries - 1;
				day = longint'({23'd0, t}) - longint'({23'd0, tab_time[e]});
				res.px = sat48(tab_px[e] + scaled_product(tab_pxr[e], day, 24));
				res.py = sat48(tab_py[e] + scaled_product(tab_pyr[e], day, 24));
				res.ut = sat48(tab_ut[e] - scaled_product(tab_lod[e], day, 24));
				res.lod = tab_lod[e][47:0];
			end else begin
				// binary search for the bracketing pair
				j = 0;
				hi = n_entries - 1;
				while (j + 1 < hi) begin
					mid = (j + hi) / 2;
					if (t < tab_time[mid])
						hi = mid;
					else
						j = mid;
				end
				if (tab_time[j+1] <= tab_time[j] || t < tab_time[j]) begin
					a = 64'sd1 << 31;
				end else begin
					d = 64'(tab_time[j+1] - tab_time[j]);
					r = 64'(t - tab_time[j]);
					if (r >= d)
						r = d - 1;
					q = (128'(r) << 32) / 128'(d);
					a = longint'(q[31:0]) & 64'hFFFF_FFFF;
				end
				res.px = blend(tab_px[j], tab_px[j+1], a);
				res.py = blend(tab_py[j], tab_py[j+1], a);
				res.ut = blend(tab_ut[j], tab_ut[j+1], a);
				res.lod = blend(tab_lod[j], tab_lod[j+1], a);
			end
		end else if (k == KIND_APPEND) begin
			if (n_entries >= TABLE_DEPTH)
				res.st = ST_FULL;
		end
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h, expected %h", what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		eop_result_t want;
		if (!arst_n) begin
			n_entries <= 0;
			fail_count = 0;
			result_q.delete();
		end else begin
			// compare the result transaction with the oldest prediction
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					report_mismatch("unexpected result", 64'(status), 64'd0);
				end else begin
					want = result_q.pop_front();
					if (status !== want.st)
						report_mismatch("status", 64'(status), 64'(want.st));
					if (pole_x_out !== want.px)
						report_mismatch("pole_x_out", 64'(pole_x_out), 64'(want.px));
					if (pole_y_out !== want.py)
						report_mismatch("pole_y_out", 64'(pole_y_out), 64'(want.py));
					if (ut1_minus_utc_out !== want.ut)
						report_mismatch("ut1_minus_utc_out", 64'(ut1_minus_utc_out),
							64'(want.ut));
					if (day_length_out !== want.lod)
						report_mismatch("day_length_out", 64'(day_length_out),
							64'(want.lod));
					if (leap_seconds_out !== want.leap)
						report_mismatch("leap_seconds_out", 64'(leap_seconds_out),
							64'(want.leap));
				end
			end
			// predict, then update the table copy
			if (in_valid && in_ready) begin
				result_q.push_back(predict_result(kind, time_days, leap_seconds_in));
				if (kind == KIND_APPEND && n_entries < TABLE_DEPTH) begin
					tab_time[n_entries] = time_days;
					tab_px[n_entries]   = longint'(pole_x);
					tab_py[n_entries]   = longint'(pole_y);
					tab_ut[n_entries]   = longint'(ut1_minus_utc);
					tab_lod[n_entries]  = longint'(day_length_excess);
					tab_pxr[n_entries]  = longint'(pole_x_rate);
					tab_pyr[n_entries]  = longint'(pole_y_rate);
					n_entries <= n_entries + 1;
				end else if (kind == KIND_CLEAR) begin
					n_entries <= 0;
				end
			end
		end
	end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives query, append, clear and unused-kind transactions into the earth rotation
// table interpolator with random idling on both channels and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import ertic_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 5000;
	localparam logic [40:0] T_MAX = {41{1'b1}};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [1:0]        kind = '0;
	logic [40:0]       time_days = '0;
	logic signed [47:0] pole_x = '0, pole_y = '0, ut1_minus_utc = '0;
	logic signed [47:0] day_length_excess = '0, pole_x_rate = '0, pole_y_rate = '0;
	logic [7:0]        leap_seconds_in = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [1:0]        status;
	logic signed [47:0] pole_x_out, pole_y_out, ut1_minus_utc_out, day_length_out;
	logic [7:0]        leap_seconds_out;
	int                fail_count, pending;

	int          send_idle_pct, recv_idle_pct;
	int          stall_cycles = 0;
	int          n_entries = 0;
	logic [40:0] t_first, t_last;

	always #4 clk = ~clk;

	earth_rotation_table_interpolator_core dut (.*);

	ertic_checker u_checker (.*);

	// randomly stall the result channel
	always @(negedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic [47:0] rand_value();
		case ($urandom_range(0, 9))
			0: return 48'h7FFF_FFFF_FFFF;
			1: return 48'h8000_0000_0000;
			2: return 48'(int'($urandom_range(0, 2000)) - 1000);
			default: return 48'({$urandom, $urandom});
		endcase
	endfunction

	function automatic logic [40:0] rand_time();
		return 41'({$urandom, $urandom});
	endfunction

	task automatic send_item(logic [1:0] k, logic [40:0] t, logic [47:0] px,
			logic [47:0] py, logic [47:0] ut, logic [47:0] lod, logic [47:0] pxr,
			logic [47:0] pyr, logic [7:0] leap);
		// hold off for a random gap
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		kind = k;
		time_days = t;
		pole_x = px;
		pole_y = py;
		ut1_minus_utc = ut;
		day_length_excess = lod;
		pole_x_rate = pxr;
		pole_y_rate = pyr;
		leap_seconds_in = leap;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		// track table bounds for aiming queries
		if (k == KIND_APPEND && n_entries < TABLE_DEPTH) begin
			if (n_entries == 0)
				t_first = t;
			t_last = t;
			n_entries++;
		end else if (k == KIND_CLEAR) begin
			n_entries = 0;
		end
	endtask

	task automatic send_append(logic [40:0] t);
		send_item(KIND_APPEND, t, rand_value(), rand_value(), rand_value(),
			rand_value(), rand_value(), rand_value(), 8'($urandom));
	endtask

	task automatic send_query(logic [40:0] t);
		send_item(KIND_QUERY, t, rand_value(), rand_value(), rand_value(),
			rand_value(), rand_value(), rand_value(), 8'($urandom));
	endtask

	function automatic logic [40:0] next_stamp();
		logic [63:0] t;
		if (n_entries == 0)
			return ($urandom_range(0, 3) == 0) ? rand_time() : 41'($urandom_range(0, 1 << 30));
		case ($urandom_range(0, 9))
			0: t = 64'(t_last);
			1, 2: t = 64'(t_last) + 64'($urandom);
			default: t = 64'(t_last) + 64'($urandom_range(1, 1 << 24));
		endcase
		return (t > 64'(T_MAX)) ? T_MAX : t[40:0];
	endfunction

	function automatic logic [40:0] query_stamp();
		logic [63:0] lo, hi;
		if (n_entries == 0 || $urandom_range(0, 9) == 0)
			return rand_time();
		lo = (t_first > 41'd4000000) ? 64'(t_first) - 64'd4000000 : 64'd0;
		hi = 64'(t_last) + 64'd4000000;
		if (hi > 64'(T_MAX))
			hi = 64'(T_MAX);
		case ($urandom_range(0, 5))
			0: return t_first;
			1: return t_last;
			default: return 41'(lo + ((64'({$urandom, $urandom})) % (hi - lo + 64'd1)));
		endcase
	endfunction

	// grow the table to a target size with queries mixed in
	task automatic run_grow(int target);
		int c;
		while (n_entries < target) begin
			c = $urandom_range(0, 99);
			if (c < 93)
				send_append(next_stamp());
			else if (c < 94)
				send_append(rand_time());
			else if (c < 99)
				send_query(query_stamp());
			else
				send_item(KIND_UNUSED, rand_time(), rand_value(), rand_value(),
					rand_value(), rand_value(), rand_value(), rand_value(), 8'($urandom));
		end
	endtask

	initial begin
		send_idle_pct = 11;
		recv_idle_pct = 49;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty table, ends, brackets, equal stamps, saturation
		send_query(41'd100);
		send_item(KIND_UNUSED, T_MAX, '1, '1, '1, '1, '1, '1, 8'hFF);
		send_item(KIND_APPEND, 41'd0, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000,
			48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF,
			48'h8000_0000_0000, 8'd0);
		send_query(41'd0);
		send_query(T_MAX);
		send_item(KIND_APPEND, 41'd1 << 24, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF,
			48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000,
			48'h7FFF_FFFF_FFFF, 8'd0);
		send_query(41'd1 << 23);
		send_query(41'd1);
		send_append(41'd1 << 24);
		send_append(41'd3 << 24);
		send_query(41'd1 << 24);
		send_query((41'd1 << 24) + 41'd5);
		send_query(41'd5 << 23);
		send_query(T_MAX);
		send_append(T_MAX);
		send_query(T_MAX);
		send_query(T_MAX - 41'd1);
		send_item(KIND_QUERY, 41'd2 << 24, '0, '0, '0, '0, '0, '0, 8'hFF);
		send_append(41'd7);
		send_query(41'd9 << 24);
		send_item(KIND_CLEAR, 41'd0, '0, '0, '0, '0, '0, '0, 8'd0);
		send_query(41'd0);

		// fill the table to the brim over the three idling phases
		run_grow(340);
		send_idle_pct = 49;
		recv_idle_pct = 11;
		run_grow(680);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_grow(TABLE_DEPTH);

		// push past the full table, then query it
		send_append(next_stamp());
		send_append(T_MAX);
		for (int n = 0; n < 12; n++)
			send_query(query_stamp());
		in_valid = 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> files.f
+incdir+design
design/ertic_pkg.sv
design/ertic_ram.sv
design/ertic_scale.sv
design/earth_rotation_table_interpolator_core.sv
tb/ertic_checker.sv
tb/tb_top.sv
